/* sv/sfbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbs_pkg - shared types and constants of the sliced Fenwick box sum
// Field widths, stream packing positions and item kind codes.
// ----------------------------------------------------------------------------
package sfbs_pkg;

  // item kinds carried on in_tuser
  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // field widths
  localparam int COORD_W  = 7;
  localparam int AMOUNT_W = 32;
  localparam int SUM_W    = 64;

  // input tdata packing, lowest bit first
  localparam int X_LOW_LSB   = 0;
  localparam int Y_LOW_LSB   = X_LOW_LSB + COORD_W;
  localparam int Z_LOW_LSB   = Y_LOW_LSB + COORD_W;
  localparam int X_HIGH_LSB  = Z_LOW_LSB + COORD_W;
  localparam int Y_HIGH_LSB  = X_HIGH_LSB + COORD_W;
  localparam int Z_HIGH_LSB  = Y_HIGH_LSB + COORD_W;
  localparam int AMOUNT_LSB  = Z_HIGH_LSB + COORD_W;
  localparam int IN_USED_W   = AMOUNT_LSB + AMOUNT_W;
  localparam int IN_TDATA_W  = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = SUM_W;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SUM_W-1:0]   sum_t;

endpackage

/* sv/sliced_fenwick_box_sum_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliced_fenwick_box_sum_top - box sums over a cube of Fenwick trees
// One 2D binary indexed tree per z slice, kept in a single synchronous RAM.
// ----------------------------------------------------------------------------
// Usage
//   in_*  : one item per handshake; in_tuser is the kind (add or query),
//           in_tdata the coordinates and the signed amount.
//   out_* : one 64-bit wrapping box sum for each query item; adds give none.
//   After reset a clearing pass writes zero to every RAM word, one word a
//   cycle, over all 2^(3*ceil(log2 SIDE)) words (2097152 for SIDE = 128).
//   in_tready stays low until it ends.
//   Items are handled one at a time by a sequencer around the single RAM.
//   An add does a read-modify-write per tree cell, a read state then a
//   write state, over up to (ceil(log2 SIDE)+1)^2 cells: 64 for SIDE = 128.
//   A query issues one RAM read a cycle while it walks a prefix term, with
//   a setup state before each of the four terms per slice and drain and done
//   states to finish: for SIDE = 128 at most 7 x 7 reads per term. The
//   single RAM read port sets this pace.
//   A finished sum waits in an output register; a stalled receiver holds up
//   the block only when the next query sum is ready and the register is full.
// ----------------------------------------------------------------------------
module sliced_fenwick_box_sum_top #(
  parameter int SIDE = 128
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // in_tdata: x_low, y_low, z_low, x_high, y_high, z_high, amount, zero pad
  input  logic [sfbs_pkg::IN_TDATA_W-1:0]   in_tdata,
  // in_tuser: opcode
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: box_sum
  output logic [sfbs_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready
);

  import sfbs_pkg::*;

  localparam int IW    = $clog2(SIDE);
  localparam int KW0   = IW + 2;
  localparam int KW    = (KW0 > 8) ? KW0 : 8;
  localparam int AW    = 3 * IW;
  localparam int DEPTH = 1 << AW;

  localparam logic [KW-1:0] SIDE_K = KW'(SIDE);
  localparam logic [KW-1:0] ONE_K  = KW'(1);

  // sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLR   = 3'd1;
  localparam logic [2:0] ST_ADDRD = 3'd2;
  localparam logic [2:0] ST_ADDWR = 3'd3;
  localparam logic [2:0] ST_QTERM = 3'd4;
  localparam logic [2:0] ST_QRD   = 3'd5;
  localparam logic [2:0] ST_QDRN  = 3'd6;
  localparam logic [2:0] ST_QDONE = 3'd7;

  function automatic logic [KW-1:0] low_bit(input logic [KW-1:0] v);
    return v & (~v + ONE_K);
  endfunction

  function automatic logic [KW-1:0] clamp(input logic [KW-1:0] v);
    return (v >= SIDE_K) ? (SIDE_K - ONE_K) : v;
  endfunction

  // unpacked input fields
  logic [KW-1:0] f_xl, f_yl, f_zl, f_xh, f_yh, f_zh;
  sum_t          f_amt;

  assign f_xl  = KW'(in_tdata[X_LOW_LSB  +: COORD_W]);
  assign f_yl  = KW'(in_tdata[Y_LOW_LSB  +: COORD_W]);
  assign f_zl  = KW'(in_tdata[Z_LOW_LSB  +: COORD_W]);
  assign f_xh  = KW'(in_tdata[X_HIGH_LSB +: COORD_W]);
  assign f_yh  = KW'(in_tdata[Y_HIGH_LSB +: COORD_W]);
  assign f_zh  = KW'(in_tdata[Z_HIGH_LSB +: COORD_W]);
  assign f_amt = SUM_W'(signed'(in_tdata[AMOUNT_LSB +: AMOUNT_W]));

  // registers
  logic [2:0]    st_r, st_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [KW-1:0] i_r, i_nxt, j_r, j_nxt, yst_r, yst_nxt;
  logic [KW-1:0] z_r, z_nxt, ztop_r, ztop_nxt;
  logic [KW-1:0] hx_r, hx_nxt, hy_r, hy_nxt, lx_r, lx_nxt, ly_r, ly_nxt;
  logic          xnz_r, xnz_nxt, ynz_r, ynz_nxt;
  logic [1:0]    term_r, term_nxt;
  logic          sign_r, sign_nxt;
  logic          rd_vld_r, rd_vld_nxt, rd_sign_r, rd_sign_nxt;
  sum_t          amt_r, amt_nxt, acc_r, acc_nxt;
  logic          out_valid_r, out_valid_nxt;
  sum_t          out_data_r, out_data_nxt;

  // RAM port signals
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, cell_addr;
  sum_t          ram_wdata, ram_rdata;

  // cell address from slice and 1-based tree indices
  logic [KW-1:0] im1, jm1;
  assign im1       = i_r - ONE_K;
  assign jm1       = j_r - ONE_K;
  assign cell_addr = {z_r[IW-1:0], im1[IW-1:0], jm1[IW-1:0]};

  // Fenwick stepping helpers
  logic [KW-1:0] j_up, i_up, j_dn, i_dn;
  assign j_up = j_r + low_bit(j_r);
  assign i_up = i_r + low_bit(i_r);
  assign j_dn = j_r & (j_r - ONE_K);
  assign i_dn = i_r & (i_r - ONE_K);

  // current prefix term selection
  logic          term_en;
  logic [KW-1:0] term_px, term_py;
  always_comb begin
    case (term_r)
      2'd0: begin
        term_en = 1'b1;
        term_px = hx_r;
        term_py = hy_r;
      end
      2'd1: begin
        term_en = ynz_r;
        term_px = hx_r;
        term_py = ly_r;
      end
      2'd2: begin
        term_en = xnz_r;
        term_px = lx_r;
        term_py = hy_r;
      end
      default: begin
        term_en = xnz_r & ynz_r;
        term_px = lx_r;
        term_py = ly_r;
      end
    endcase
  end

  // next term or next slice
  logic [1:0]    term_adv;
  logic [KW-1:0] z_adv;
  assign term_adv = term_r + 2'd1;
  assign z_adv    = (term_r == 2'd3) ? (z_r + ONE_K) : z_r;

  assign in_tready = (st_r == ST_IDLE);

  // sequencer
  always_comb begin
    st_nxt        = st_r;
    clr_cnt_nxt   = clr_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    yst_nxt       = yst_r;
    z_nxt         = z_r;
    ztop_nxt      = ztop_r;
    hx_nxt        = hx_r;
    hy_nxt        = hy_r;
    lx_nxt        = lx_r;
    ly_nxt        = ly_r;
    xnz_nxt       = xnz_r;
    ynz_nxt       = ynz_r;
    term_nxt      = term_r;
    sign_nxt      = sign_r;
    rd_vld_nxt    = 1'b0;
    rd_sign_nxt   = sign_r;
    amt_nxt       = amt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr;
    ram_wdata     = ram_rdata + amt_r;
    ram_re        = 1'b0;

    // accumulate read data in the cycle after its issue
    if (rd_vld_r) begin
      acc_nxt = rd_sign_r ? (acc_r - ram_rdata) : (acc_r + ram_rdata);
    end

    case (st_r)
      ST_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          amt_nxt = f_amt;
          if (in_tuser == OP_ADD) begin
            // adds outside the cube are dropped
            if (f_xl < SIDE_K && f_yl < SIDE_K && f_zl < SIDE_K) begin
              i_nxt   = f_xl + ONE_K;
              j_nxt   = f_yl + ONE_K;
              yst_nxt = f_yl + ONE_K;
              z_nxt   = f_zl;
              st_nxt  = ST_ADDRD;
            end
          end else begin
            hx_nxt   = clamp(f_xh) + ONE_K;
            hy_nxt   = clamp(f_yh) + ONE_K;
            lx_nxt   = clamp(f_xl - ONE_K) + ONE_K;
            ly_nxt   = clamp(f_yl - ONE_K) + ONE_K;
            xnz_nxt  = (f_xl != '0);
            ynz_nxt  = (f_yl != '0);
            z_nxt    = f_zl;
            ztop_nxt = clamp(f_zh);
            term_nxt = 2'd0;
            acc_nxt  = '0;
            st_nxt   = ST_QTERM;
          end
        end
      end
      ST_ADDRD: begin
        ram_re = 1'b1;
        st_nxt = ST_ADDWR;
      end
      ST_ADDWR: begin
        // write back and step up the paths in y, then x
        ram_we = 1'b1;
        st_nxt = ST_ADDRD;
        if (j_up <= SIDE_K) begin
          j_nxt = j_up;
        end else if (i_up <= SIDE_K) begin
          i_nxt = i_up;
          j_nxt = yst_r;
        end else begin
          st_nxt = ST_IDLE;
        end
      end
      ST_QTERM: begin
        if (z_r > ztop_r) begin
          st_nxt = ST_QDRN;
        end else if (term_en) begin
          i_nxt    = term_px;
          j_nxt    = term_py;
          yst_nxt  = term_py;
          sign_nxt = (term_r == 2'd1) || (term_r == 2'd2);
          st_nxt   = ST_QRD;
        end else begin
          term_nxt = term_adv;
          z_nxt    = z_adv;
        end
      end
      ST_QRD: begin
        // one read a cycle down the paths in y, then x
        ram_re     = 1'b1;
        rd_vld_nxt = 1'b1;
        if (j_dn != '0) begin
          j_nxt = j_dn;
        end else if (i_dn != '0) begin
          i_nxt = i_dn;
          j_nxt = yst_r;
        end else begin
          term_nxt = term_adv;
          z_nxt    = z_adv;
          st_nxt   = ST_QTERM;
        end
      end
      ST_QDRN: begin
        st_nxt = ST_QDONE;
      end
      ST_QDONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
          st_nxt        = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLR;
      clr_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    yst_r      <= yst_nxt;
    z_r        <= z_nxt;
    ztop_r     <= ztop_nxt;
    hx_r       <= hx_nxt;
    hy_r       <= hy_nxt;
    lx_r       <= lx_nxt;
    ly_r       <= ly_nxt;
    xnz_r      <= xnz_nxt;
    ynz_r      <= ynz_nxt;
    term_r     <= term_nxt;
    sign_r     <= sign_nxt;
    rd_sign_r  <= rd_sign_nxt;
    amt_r      <= amt_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // tree cell store
  sfbs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (DEPTH)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  // read data is only accumulated right after a query read
  a_rd_vld_src: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(st_r == ST_QRD))
    else $error("accumulate without a preceding query read");

  // tree indices stay 1-based while the RAM is addressed
  a_idx_nz: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_QRD || st_r == ST_ADDRD || st_r == ST_ADDWR) |->
      (i_r != '0 && j_r != '0 && i_r <= SIDE_K && j_r <= SIDE_K))
    else $error("tree index out of range");

  // all reads are folded in before the sum is handed over
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_QDONE) |-> !rd_vld_r)
    else $error("sum taken with a read still in flight");

  // no write while a query walks the store
  a_no_wr_query: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_QRD || st_r == ST_QTERM) |-> !ram_we)
    else $error("store written during a query");

  // a new sum is loaded only into a free or draining output register
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_QDONE && st_nxt == ST_IDLE) |-> (!out_valid_r || out_tready))
    else $error("pending sum overwritten");

endmodule

/* sv/sfbs_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbs_ram - generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sfbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench of the sliced Fenwick box sum
// Drives add and query items, keeps a sparse copy of the cube of counts and
// checks every box sum against an inclusion-exclusion walk over that copy.
// ----------------------------------------------------------------------------
module tb;
  import sfbs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 20_000_000;
  localparam int unsigned HOLD_CYCLES  = 20_000;
  localparam int unsigned TAIL_CYCLES  = 2_000;
  localparam int          RANDOM_ITEMS = 100;
  localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = 32'h7FFF_FFFF;
  localparam logic [AMOUNT_W-1:0] AMOUNT_MIN = 32'h8000_0000;

  typedef struct {
    logic                op;
    coord_t              x_low;
    coord_t              y_low;
    coord_t              z_low;
    coord_t              x_high;
    coord_t              y_high;
    coord_t              z_high;
    logic [AMOUNT_W-1:0] amount;
  } box_item_t;

  // sparse cube of counts: one running total per touched point
  class box_sum_scoreboard;
    sum_t        point_total [bit [3*COORD_W-1:0]];
    sum_t        expected_sums [$];
    int unsigned errors;

    function new();
      errors = 0;
    endfunction

    // every point weighs +1, 0 or -1 in x and in y and 1 or 0 in z, reversed x and y bounds included
    function sum_t box_sum_of(box_item_t it);
      sum_t   total;
      coord_t px, py, pz;
      int     wx, wy;
      total = '0;
      foreach (point_total[k]) begin
        pz = k[3*COORD_W-1:2*COORD_W];
        px = k[2*COORD_W-1:COORD_W];
        py = k[COORD_W-1:0];
        if (pz < it.z_low || pz > it.z_high) continue;
        wx = int'(px <= it.x_high) - int'(px < it.x_low);
        wy = int'(py <= it.y_high) - int'(py < it.y_low);
        if (wx * wy > 0) total += point_total[k];
        else if (wx * wy < 0) total -= point_total[k];
      end
      return total;
    endfunction

    function void note_item(box_item_t it);
      bit [3*COORD_W-1:0] key;
      key = {it.z_low, it.x_low, it.y_low};
      if (it.op == OP_ADD) begin
        if (!point_total.exists(key)) point_total[key] = '0;
        point_total[key] += {{(SUM_W-AMOUNT_W){it.amount[AMOUNT_W-1]}}, it.amount};
      end else begin
        expected_sums.push_back(box_sum_of(it));
      end
    endfunction

    function void check_sum(sum_t got);
      sum_t want;
      if (expected_sums.size() == 0) begin
        $error("box_sum: no query waiting, actual %0d", $signed(got));
        errors++;
      end else begin
        want = expected_sums.pop_front();
        if (want !== got) begin
          $error("box_sum: expected %0d, actual %0d", $signed(want), $signed(got));
          errors++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_sums.size();
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tvalid;
  logic                   out_tready;

  box_sum_scoreboard sb;
  bit                steady;
  bit                hold_out;

  sliced_fenwick_box_sum_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int unsigned idle_gap();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  function automatic box_item_t make_item(logic op, int xl, int yl, int zl,
                                          int xh, int yh, int zh,
                                          logic [AMOUNT_W-1:0] amt);
    box_item_t it;
    it.op     = op;
    it.x_low  = coord_t'(xl);
    it.y_low  = coord_t'(yl);
    it.z_low  = coord_t'(zl);
    it.x_high = coord_t'(xh);
    it.y_high = coord_t'(yh);
    it.z_high = coord_t'(zh);
    it.amount = amt;
    return it;
  endfunction

  // offer one item after a random gap, none while steady, and hold it until taken
  task automatic send_item(box_item_t it);
    logic [IN_TDATA_W-1:0] word;
    int unsigned           gap;
    gap  = idle_gap();
    word = '0;
    word[X_LOW_LSB  +: COORD_W]  = it.x_low;
    word[Y_LOW_LSB  +: COORD_W]  = it.y_low;
    word[Z_LOW_LSB  +: COORD_W]  = it.z_low;
    word[X_HIGH_LSB +: COORD_W]  = it.x_high;
    word[Y_HIGH_LSB +: COORD_W]  = it.y_high;
    word[Z_HIGH_LSB +: COORD_W]  = it.z_high;
    word[AMOUNT_LSB +: AMOUNT_W] = it.amount;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= word;
    in_tuser  <= it.op;
    do @(posedge clk); while (!in_tready);
    sb.note_item(it);
  endtask

  // sender pause until every query has been answered
  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // result side: random stalls, one long hold on request
  initial begin : receiver
    int unsigned gap;
    bit          hold_done;
    gap       = 0;
    hold_done = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        sb.check_sum(out_tdata);
        gap = idle_gap();
      end
      if (hold_out && !hold_done) begin
        hold_done = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // run limit, allows for the clearing pass after reset
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    box_item_t           it;
    int                  hot_z, zl, zh, xl, xh, yl, yh, tmp;
    int unsigned         roll;
    logic                op;
    logic [AMOUNT_W-1:0] amt;
    sb       = new();
    steady   = 1'b0;
    hold_out = 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= OP_ADD;
    rst_n     <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty cube, corner points, extreme amounts
    send_item(make_item(OP_QUERY, 0, 0, 0, 127, 127, 127, $urandom()));
    send_item(make_item(OP_ADD, 0, 0, 0, 127, 127, 127, AMOUNT_MAX));
    send_item(make_item(OP_ADD, 127, 127, 127, 0, 0, 0, AMOUNT_MIN));
    send_item(make_item(OP_ADD, 127, 0, 64, $urandom_range(0, 127),
                        $urandom_range(0, 127), $urandom_range(0, 127), '1));
    send_item(make_item(OP_ADD, 0, 127, 1, 0, 0, 0, 32'd1));
    send_item(make_item(OP_ADD, 5, 9, 2, 3, 3, 3, $urandom()));
    send_item(make_item(OP_ADD, 5, 9, 2, 0, 0, 0, AMOUNT_MAX));
    send_item(make_item(OP_ADD, 64, 64, 2, 0, 0, 0, AMOUNT_MIN));
    send_item(make_item(OP_QUERY, 0, 0, 0, 127, 127, 127, $urandom()));
    // single cells at both corners
    send_item(make_item(OP_QUERY, 0, 0, 0, 0, 0, 0, $urandom()));
    send_item(make_item(OP_QUERY, 127, 127, 127, 127, 127, 127, $urandom()));
    // empty slice ranges
    send_item(make_item(OP_QUERY, 0, 0, 5, 127, 127, 4, $urandom()));
    send_item(make_item(OP_QUERY, 0, 0, 127, 127, 127, 0, $urandom()));
    // reversed x, reversed y, both reversed
    send_item(make_item(OP_QUERY, 100, 0, 0, 3, 127, 2, $urandom()));
    send_item(make_item(OP_QUERY, 0, 120, 0, 127, 2, 2, $urandom()));
    send_item(make_item(OP_QUERY, 70, 90, 0, 1, 4, 2, $urandom()));
    // one lower bound at zero, the other not
    send_item(make_item(OP_QUERY, 0, 9, 2, 5, 9, 2, $urandom()));
    send_item(make_item(OP_QUERY, 5, 0, 0, 127, 127, 64, $urandom()));
    send_item(make_item(OP_QUERY, 127, 0, 64, 127, 0, 64, $urandom()));
    wait_results();

    // random: adds crowd a few hot slices so that queries find them
    hot_z = $urandom_range(0, 120);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 40 && n < 55) || (n >= 60 && n < 66);
      // long receiver hold while a burst of queries backs the block up
      if (n == 60) hold_out = 1'b1;
      if (n == 80) wait_results();
      op = (n >= 60 && n < 66) ? OP_QUERY
         : ($urandom_range(0, 99) < 55 ? OP_ADD : OP_QUERY);
      if (op == OP_ADD) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) amt = AMOUNT_W'($urandom_range(0, 20) - 10);
        else if (roll < 20) amt = $urandom_range(0, 1) ? AMOUNT_MAX : AMOUNT_MIN;
        else amt = $urandom();
        zl = ($urandom_range(0, 3) != 0) ? hot_z + $urandom_range(0, 7)
                                         : $urandom_range(0, 127);
        it = make_item(OP_ADD, $urandom_range(0, 127), $urandom_range(0, 127), zl,
                       $urandom_range(0, 127), $urandom_range(0, 127),
                       $urandom_range(0, 127), amt);
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
          zl = 0;
          zh = 127;
        end else if (roll < 10) begin
          zh = $urandom_range(0, 126);
          zl = $urandom_range(zh + 1, 127);
        end else begin
          zl = hot_z + $urandom_range(0, 7);
          zh = zl + $urandom_range(0, 7);
          if (zh > 127) zh = 127;
        end
        if ($urandom_range(0, 9) < 3) begin
          xl = 0;
          xh = 127;
          yl = 0;
          yh = 127;
        end else begin
          xl = $urandom_range(0, 127);
          xh = $urandom_range(0, 127);
          yl = $urandom_range(0, 127);
          yh = $urandom_range(0, 127);
          // mostly ordered bounds, some left reversed
          if ($urandom_range(0, 4) != 0 && xl > xh) begin
            tmp = xl;
            xl  = xh;
            xh  = tmp;
          end
          if ($urandom_range(0, 4) != 0 && yl > yh) begin
            tmp = yl;
            yl  = yh;
            yh  = tmp;
          end
        end
        it = make_item(OP_QUERY, xl, yl, zl, xh, yh, zh, $urandom());
      end
      send_item(it);
    end
    steady = 1'b0;
    wait_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("box_sum: %0d expected sums never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
